>>> hw/rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and codes for the bitmap page-frame allocator: request and
// response beat layouts, mode and status codes, bitmap word geometry.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   // bitmap word geometry: one memory word holds this many block bits
   localparam int WORD_BITS  = 64;
   localparam int BIT_SEL_W  = 6;

   // payload widths
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 19;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   block_address;
      logic [COUNT_W-1:0]  used_blocks;
   } rsp_type;

endpackage

>>> hw/rtl/bpfa_divider.sv
// ----------------------------------------------------------------------------
// bpfa_divider
// Division of a byte address by the constant block size through a reciprocal
// multiplication, registering the dividend and then the product with done.
// ----------------------------------------------------------------------------
module bpfa_divider #(
   parameter int DIVISOR = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bpfa_pkg::ADDR_W-1:0]  dividend,
   output logic                         done,
   output logic [bpfa_pkg::ADDR_W-1:0]  quotient
);

   // exact for every 32-bit dividend: q = (n * ceil(2^(32+l) / d)) >> (32+l),
   // l = ceil(log2 d); the reciprocal needs 33 bits
   localparam int NW     = bpfa_pkg::ADDR_W;
   localparam int SHIFT  = NW + $clog2(DIVISOR);
   localparam int PROD_W = 2 * NW + 1;
   localparam logic [63:0]   SCALE    = 64'd1 << SHIFT;
   localparam logic [63:0]   RECIP    = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [NW-1:0] RECIP_LO = RECIP[NW-1:0];
   localparam logic          RECIP_HI = RECIP[NW];

   logic                mul_ff, mul_in;
   logic                done_ff, done_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [2*NW-1:0]     low_prod;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // capture the dividend, then one 32x32 multiply plus the top reciprocal bit
   always_comb begin
      mul_in   = start;
      done_in  = mul_ff;
      num_in   = start ? dividend : num_ff;
      low_prod = {{NW{1'b0}}, num_ff} * {{NW{1'b0}}, RECIP_LO};
      prod_in  = {1'b0, low_prod};
      if (RECIP_HI) begin
         prod_in = prod_in + {1'b0, num_ff, {NW{1'b0}}};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = NW'(prod_ff >> SHIFT);

endmodule

>>> hw/rtl/bpfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bpfa_bitmap_ram
// Usage bitmap storage, one write port and one read port, 64 block bits per
// word, registered read data.
// ----------------------------------------------------------------------------
module bpfa_bitmap_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [bpfa_pkg::WORD_BITS-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [bpfa_pkg::WORD_BITS-1:0] rd_data
);

   logic [bpfa_pkg::WORD_BITS-1:0] bitmap_mem_ff [DEPTH];
   logic [bpfa_pkg::WORD_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bitmap_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bitmap_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// First-fit page-frame allocator over a used/free bitmap held in block RAM.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of 64-bit words, one bit per block, and a small
// sequencer drives it one request at a time. After reset the block writes
// every word, ceil(BITMAP_BYTES / 8) of them (4096 by default), to all-used;
// req_stall stays high meanwhile. An allocate streams the bitmap through the
// single read port one word per cycle until the first word with a free bit,
// or through the last word when memory is full. Free, reserve and release
// turn the byte address into a block index with a reciprocal multiplication
// and then do one read-modify-write; an out-of-range address is answered
// without the read-modify-write. A new request is taken while the previous
// response still waits in the output register.
module bitmap_page_frame_allocator_core #(
   parameter int BITMAP_BYTES = 32768,
   parameter int BLOCK_BYTES  = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpfa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpfa_pkg::rsp_type rsp_data
);

   localparam int WB           = bpfa_pkg::WORD_BITS;
   localparam int BW           = bpfa_pkg::BIT_SEL_W;
   localparam int CW           = bpfa_pkg::COUNT_W;
   localparam int ADW          = bpfa_pkg::ADDR_W;
   localparam int TOTAL_BLOCKS = BITMAP_BYTES * 8;
   localparam int WORDS        = (TOTAL_BLOCKS + WB - 1) / WB;
   localparam int AW           = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W        = AW + BW;
   localparam logic [CW-1:0]  COUNT_RESET = CW'(TOTAL_BLOCKS % (2 ** CW));
   localparam logic [AW-1:0]  LAST_WORD   = AW'(WORDS - 1);
   localparam logic [AW:0]    WORD_COUNT  = (AW + 1)'(WORDS);
   localparam logic [ADW-1:0] TOTAL_EXT   = ADW'(TOTAL_BLOCKS);
   localparam logic [ADW-1:0] BLOCK_EXT   = ADW'(BLOCK_BYTES);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_MODIFY = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  clr_ptr_ff, clr_ptr_in;
   logic [AW:0]                    scan_ptr_ff, scan_ptr_in;
   logic                           pend_ff, pend_in;
   logic [AW-1:0]                  pend_addr_ff, pend_addr_in;
   logic [bpfa_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [bpfa_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ADW-1:0]                 res_addr_ff, res_addr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bpfa_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [WB-1:0]                  ram_wr_data;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [WB-1:0]                  ram_rd_data;

   logic                           div_start;
   logic                           div_done;
   logic [ADW-1:0]                 div_quot;

   logic [BW-1:0]                  free_pos;
   logic                           bit_was;
   logic                           bit_want;
   logic [WB-1:0]                  mod_word;
   logic                           rsp_load;

   // address to block index
   bpfa_divider #(
      .DIVISOR (BLOCK_BYTES)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.address),
      .done     (div_done),
      .quotient (div_quot)
   );

   // bitmap storage
   bpfa_bitmap_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // lowest clear bit of the word coming out of the ram
   always_comb begin
      free_pos = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (!ram_rd_data[i]) begin
            free_pos = BW'(i);
         end
      end
   end

   // read-modify-write of one block bit
   always_comb begin
      bit_want = (mode_ff == bpfa_pkg::MODE_RESERVE);
      bit_was  = ram_rd_data[idx_ff[BW-1:0]];
      mod_word = ram_rd_data;
      mod_word[idx_ff[BW-1:0]] = bit_want;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      scan_ptr_in   = scan_ptr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[IDX_W-1:BW];
      ram_wr_data   = mod_word;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[IDX_W-1:BW];
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ptr_ff;
            ram_wr_data = '1;
            if (clr_ptr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_data.mode;
               res_status_in = bpfa_pkg::STATUS_OK;
               res_addr_in   = '0;
               if (req_data.mode == bpfa_pkg::MODE_ALLOC) begin
                  scan_ptr_in = '0;
                  state_in    = ST_SCAN;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_SCAN: begin
            // issue the next word while checking the one read last cycle
            if (scan_ptr_ff < WORD_COUNT) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = scan_ptr_ff[AW-1:0];
               scan_ptr_in  = scan_ptr_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = scan_ptr_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (ram_rd_data != '1) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pend_addr_ff;
                  ram_wr_data = ram_rd_data | (WB'(1) << free_pos);
                  idx_in      = {pend_addr_ff, free_pos};
                  count_in    = count_ff + 1'b1;
                  state_in    = ST_MUL;
               end else if (pend_addr_ff == LAST_WORD) begin
                  res_status_in = bpfa_pkg::STATUS_NOMEM;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_MUL: begin
            res_addr_in = ADW'(idx_ff) * BLOCK_EXT;
            state_in    = ST_RESP;
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quot >= TOTAL_EXT) begin
                  res_status_in = bpfa_pkg::STATUS_RANGE;
                  state_in      = ST_RESP;
               end else begin
                  idx_in   = div_quot[IDX_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            // count moves only when the bit really flips
            if (bit_was != bit_want) begin
               ram_wr_en = 1'b1;
               count_in  = bit_want ? count_ff + 1'b1 : count_ff - 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response beat register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = res_status_ff;
         rsp_data_in.block_address = res_addr_ff;
         rsp_data_in.used_blocks   = count_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      pend_addr_ff  <= pend_addr_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
